// ----- sv/endpoint_pair_check_table_macros.svh -----
// Assertion macros for the endpoint pair check table.
// Used by the controller; expects clk_i and rst_ni in the enclosing module.
`ifndef ENDPOINT_PAIR_CHECK_TABLE_MACROS_SVH
`define ENDPOINT_PAIR_CHECK_TABLE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define EPCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EPCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/epct_pkg.sv -----
// Shared types, constants and helper functions for the endpoint pair check table.
// No dependencies; used by the controller, the datapath and the top level.
package epct_pkg;

  // Default table depth.
  localparam int TableDepth = 8;

  // Item kinds.
  localparam logic [1:0] KindPacket = 2'd0;
  localparam logic [1:0] KindCreate = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;
  localparam logic [1:0] KindDrive  = 2'd3;

  // Packet types.
  localparam logic [7:0] PktRequest  = 8'd0;
  localparam logic [7:0] PktResponse = 8'd1;

  // Side states.
  localparam logic [1:0] StInit = 2'd0;
  localparam logic [1:0] StMid  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // Result status codes.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatExists   = 2'd1;
  localparam logic [1:0] StatNotFound = 2'd2;
  localparam logic [1:0] StatFull     = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic CfgRetry   = 1'b0;
  localparam logic CfgTimeout = 1'b1;
  localparam logic [15:0] RetryReset   = 16'd2;
  localparam logic [15:0] TimeoutReset = 16'd10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] local_endpoint;
    logic [47:0] remote_endpoint;
    logic [7:0]  packet_type;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [47:0] pair_local;
    logic [47:0] pair_remote;
    logic        send_request;
    logic [1:0]  responses_sent;
    logic        changed;
    logic [1:0]  out_side_state;
    logic [1:0]  answer_side_state;
    logic        timed_out;
    logic [1:0]  status;
    logic [4:0]  event_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [47:0] loc;
    logic [47:0] rem;
    logic [1:0]  out_st;
    logic [1:0]  ans_st;
    logic        resend;
    logic [31:0] first_req;
    logic [31:0] last_req;
    logic        pend;
  } entry_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CAPTURE = 3'd1,
    OP_SIMPLE  = 3'd2,
    OP_EMPTY   = 3'd3,
    OP_DRIVE   = 3'd4,
    OP_COPY    = 3'd5
  } op_e;

  typedef struct packed {
    op_e  op;
    logic hit;
    logic full;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic       match;
    logic       drop;
    logic       out_free;
    logic [1:0] kind;
    logic       ptype_req;
  } sts_t;

  // Signed modular elapsed time has reached a limit; a zero limit acts as one.
  function automatic logic reached(logic [31:0] now, logic [31:0] then, logic [15:0] lim);
    logic [31:0] d;
    logic [15:0] l;
    d = now - then;
    l = (lim == 16'd0) ? 16'd1 : lim;
    return !d[31] && (d >= {16'd0, l});
  endfunction

endpackage

// ----- sv/epct_dpath.sv -----
// Datapath of the endpoint pair check table: item register, table storage,
// per-entry update logic, configuration registers and output register. Uses epct_pkg.
module epct_dpath #(
  parameter int Depth = epct_pkg::TableDepth,
  parameter int IdxW  = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  epct_pkg::in_item_t   in_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  epct_pkg::cmd_t       cmd_i,
  input  logic [IdxW-1:0]      rd_idx_i,
  input  logic [IdxW-1:0]      wr_idx_i,
  output epct_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  output epct_pkg::out_item_t  out_data_o,
  input  logic                 out_stall_i
);

  epct_pkg::in_item_t  item_q;
  epct_pkg::entry_t    table_q [Depth];
  epct_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;
  logic [15:0]         rint_q, tmo_q;
  logic [4:0]          events_q;

  epct_pkg::entry_t    rd_e, smp_e, drv_e;
  epct_pkg::out_item_t smp_res, drv_res;
  logic                smp_wr, smp_valid, drop, req;
  logic [1:0]          smp_stat, resp;
  logic [4:0]          evt_sum;

  assign rd_e = table_q[rd_idx_i];

  // Status back to the controller.
  always_comb begin
    sts_o.match     = (rd_e.loc == item_q.local_endpoint) &&
                      (rd_e.rem == item_q.remote_endpoint);
    sts_o.drop      = drop;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.kind      = item_q.kind;
    sts_o.ptype_req = (item_q.packet_type == epct_pkg::PktRequest);
  end

  // Packet, create and remove handling for one looked-up entry.
  always_comb begin
    if (cmd_i.hit) begin
      smp_e = rd_e;
    end else begin
      smp_e = '0;
      smp_e.loc = item_q.local_endpoint;
      smp_e.rem = item_q.remote_endpoint;
    end
    smp_wr = 1'b0;
    smp_valid = cmd_i.hit;
    smp_stat = cmd_i.hit ? epct_pkg::StatOk : epct_pkg::StatNotFound;
    case (item_q.kind)
      epct_pkg::KindPacket: begin
        if (item_q.packet_type == epct_pkg::PktResponse) begin
          if (cmd_i.hit && smp_e.out_st == epct_pkg::StMid) begin
            smp_e.out_st = epct_pkg::StDone;
            smp_e.pend = 1'b1;
          end
          smp_wr = cmd_i.hit;
        end else if (item_q.packet_type == epct_pkg::PktRequest) begin
          if (!cmd_i.hit && cmd_i.full) begin
            smp_stat = epct_pkg::StatFull;
          end else begin
            if (smp_e.ans_st == epct_pkg::StInit) begin
              smp_e.ans_st = epct_pkg::StMid;
              smp_e.pend = 1'b1;
            end else if (smp_e.ans_st == epct_pkg::StDone) begin
              smp_e.resend = 1'b1;
            end
            smp_wr = 1'b1;
            smp_valid = 1'b1;
            smp_stat = epct_pkg::StatOk;
          end
        end
      end
      epct_pkg::KindCreate: begin
        if (cmd_i.hit) begin
          smp_stat = epct_pkg::StatExists;
        end else if (cmd_i.full) begin
          smp_stat = epct_pkg::StatFull;
        end else begin
          smp_wr = 1'b1;
          smp_valid = 1'b1;
          smp_stat = epct_pkg::StatOk;
        end
      end
      default: begin
      end
    endcase
    smp_res = '0;
    smp_res.last = 1'b1;
    smp_res.status = smp_stat;
    if (smp_valid) begin
      smp_res.entry_valid = 1'b1;
      smp_res.pair_local = smp_e.loc;
      smp_res.pair_remote = smp_e.rem;
      smp_res.out_side_state = smp_e.out_st;
      smp_res.answer_side_state = smp_e.ans_st;
    end
  end

  // Drive pass update of one entry.
  always_comb begin
    drv_e = rd_e;
    req = 1'b0;
    resp = 2'd0;
    drop = 1'b0;
    if (drv_e.out_st == epct_pkg::StInit) begin
      drv_e.out_st = epct_pkg::StMid;
      drv_e.first_req = item_q.now;
      drv_e.last_req = item_q.now;
      drv_e.pend = 1'b1;
      req = 1'b1;
    end
    if (drv_e.out_st == epct_pkg::StMid) begin
      if (epct_pkg::reached(item_q.now, drv_e.first_req, tmo_q)) begin
        drop = 1'b1;
      end else if (epct_pkg::reached(item_q.now, drv_e.last_req, rint_q)) begin
        drv_e.last_req = item_q.now;
        req = 1'b1;
      end
    end
    if (drv_e.ans_st == epct_pkg::StMid) begin
      drv_e.ans_st = epct_pkg::StDone;
      drv_e.pend = 1'b1;
      resp = 2'd1;
    end
    if (drv_e.ans_st == epct_pkg::StDone && drv_e.resend) begin
      drv_e.resend = 1'b0;
      resp = resp + 2'd1;
    end
    evt_sum = events_q + {4'd0, req} + {3'd0, resp};
    drv_res = '0;
    drv_res.entry_valid = 1'b1;
    drv_res.pair_local = drv_e.loc;
    drv_res.pair_remote = drv_e.rem;
    drv_res.send_request = req;
    drv_res.responses_sent = resp;
    drv_res.changed = drv_e.pend;
    drv_res.out_side_state = drv_e.out_st;
    drv_res.answer_side_state = drv_e.ans_st;
    drv_res.timed_out = drop;
    drv_res.status = epct_pkg::StatOk;
    drv_res.event_total = evt_sum;
    drv_res.last = cmd_i.last;
    drv_e.pend = 1'b0;
  end

  // Output beat selection.
  always_comb begin
    case (cmd_i.op)
      epct_pkg::OP_SIMPLE: out_d = smp_res;
      epct_pkg::OP_DRIVE:  out_d = drv_res;
      default: begin
        out_d = '0;
        out_d.last = 1'b1;
      end
    endcase
  end

  // Control registers: output valid, configuration, event count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rint_q <= epct_pkg::RetryReset;
      tmo_q <= epct_pkg::TimeoutReset;
      events_q <= 5'd0;
    end else begin
      if (cmd_i.op == epct_pkg::OP_SIMPLE || cmd_i.op == epct_pkg::OP_EMPTY ||
          cmd_i.op == epct_pkg::OP_DRIVE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == epct_pkg::CfgRetry) begin
          rint_q <= cfg_data_i;
        end else begin
          tmo_q <= cfg_data_i;
        end
      end
      if (cmd_i.op == epct_pkg::OP_CAPTURE) begin
        events_q <= 5'd0;
      end else if (cmd_i.op == epct_pkg::OP_DRIVE) begin
        events_q <= evt_sum;
      end
    end
  end

  // Payload registers and table storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == epct_pkg::OP_CAPTURE) begin
      item_q <= in_data_i;
    end
    if (cmd_i.op == epct_pkg::OP_SIMPLE || cmd_i.op == epct_pkg::OP_EMPTY ||
        cmd_i.op == epct_pkg::OP_DRIVE) begin
      out_q <= out_d;
    end
    case (cmd_i.op)
      epct_pkg::OP_SIMPLE: if (smp_wr) table_q[wr_idx_i] <= smp_e;
      epct_pkg::OP_DRIVE:  if (!drop) table_q[wr_idx_i] <= drv_e;
      epct_pkg::OP_COPY:   table_q[wr_idx_i] <= rd_e;
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ----- sv/epct_ctrl.sv -----
// Controller of the endpoint pair check table: sequences lookup, update,
// compaction and drive passes, and keeps the entry count. Uses epct_pkg and the macros header.
`include "endpoint_pair_check_table_macros.svh"
module epct_ctrl #(
  parameter int Depth = epct_pkg::TableDepth,
  parameter int IdxW  = 3,
  parameter int CntW  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      in_kind_i,
  input  epct_pkg::sts_t  sts_i,
  output epct_pkg::cmd_t  cmd_o,
  output logic [IdxW-1:0] rd_idx_o,
  output logic [IdxW-1:0] wr_idx_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_SIMPLE  = 5'b00100,
    S_COMPACT = 5'b01000,
    S_DRIVE   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, w_q, w_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hidx_q, hidx_d;
  logic [CntW-1:0] i_inc;
  logic            full, add;

  assign i_inc = i_q + CntW'(1);
  assign full = (cnt_q == CntW'(Depth));
  assign add = !hit_q && !full && ((sts_i.kind == epct_pkg::KindCreate) ||
               (sts_i.kind == epct_pkg::KindPacket && sts_i.ptype_req));
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    i_d = i_q;
    w_d = w_q;
    hit_d = hit_q;
    hidx_d = hidx_q;
    cmd_o = '0;
    cmd_o.op = epct_pkg::OP_NONE;
    rd_idx_o = i_q[IdxW-1:0];
    wr_idx_o = w_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = epct_pkg::OP_CAPTURE;
          i_d = '0;
          w_d = '0;
          state_d = (in_kind_i == epct_pkg::KindDrive) ? S_DRIVE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (i_q >= cnt_q) begin
          hit_d = 1'b0;
          state_d = S_SIMPLE;
        end else if (sts_i.match) begin
          hit_d = 1'b1;
          hidx_d = i_q[IdxW-1:0];
          state_d = S_SIMPLE;
        end else begin
          i_d = i_inc;
        end
      end
      S_SIMPLE: begin
        rd_idx_o = hidx_q;
        wr_idx_o = hit_q ? hidx_q : cnt_q[IdxW-1:0];
        cmd_o.hit = hit_q;
        cmd_o.full = full;
        if (sts_i.out_free) begin
          cmd_o.op = epct_pkg::OP_SIMPLE;
          if (add) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (sts_i.kind == epct_pkg::KindRemove && hit_q) begin
            i_d = CntW'(hidx_q);
            state_d = S_COMPACT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_COMPACT: begin
        rd_idx_o = i_inc[IdxW-1:0];
        wr_idx_o = i_q[IdxW-1:0];
        if (i_inc < cnt_q) begin
          cmd_o.op = epct_pkg::OP_COPY;
          i_d = i_inc;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          state_d = S_IDLE;
        end
      end
      S_DRIVE: begin
        cmd_o.last = (i_inc == cnt_q);
        if (sts_i.out_free) begin
          if (cnt_q == '0) begin
            cmd_o.op = epct_pkg::OP_EMPTY;
            state_d = S_IDLE;
          end else begin
            cmd_o.op = epct_pkg::OP_DRIVE;
            if (!sts_i.drop) begin
              w_d = w_q + CntW'(1);
            end
            i_d = i_inc;
            if (i_inc == cnt_q) begin
              cnt_d = w_d;
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      i_q <= '0;
      w_q <= '0;
      hit_q <= 1'b0;
      hidx_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      i_q <= i_d;
      w_q <= w_d;
      hit_q <= hit_d;
      hidx_q <= hidx_d;
    end
  end

  `EPCT_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "entry count above depth")
  `EPCT_ASSERT(a_scan_bound, state_q == S_SCAN |-> i_q <= cnt_q, "scan index past count")
  `EPCT_ASSERT(a_compact_bound, state_q == S_COMPACT |-> i_q < cnt_q,
               "compaction index past count")
  `EPCT_ASSERT(a_drive_end, (state_q == S_DRIVE && cmd_o.op == epct_pkg::OP_DRIVE && cmd_o.last)
               |=> state_q == S_IDLE, "drive pass did not end")

endmodule

// ----- sv/endpoint_pair_check_table.sv -----
// Top level of the endpoint pair check table.
// Instantiates epct_ctrl and epct_dpath; uses epct_pkg.
//
// Usage: items enter on in_valid_i/in_stall_o/in_data_i and are accepted when
// valid is high and stall is low. Result beats leave on out_valid_o/out_data_o
// and are taken when out_stall_i is low; the last beat of an item has last set.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i (0 retry
// interval, 1 check timeout) and cfg_data_i; ready is always high.
// Packet, create and remove items scan the table one entry per cycle, then
// emit one beat once the output register is free; the scan ends at a hit or
// after the last stored entry. Removing an entry compacts the table after the
// beat, moving each later entry down by one. A drive pass emits one beat per
// entry per cycle while the receiver does not stall; an empty table gives a
// single beat. The next item can be taken in the cycle after the last beat is
// loaded (after compaction for a remove). Scans and drive passes walk only the
// stored entries. One item is in work at a time; in_stall_o is high until done.
// A stalled receiver holds the output register and freezes the drive walk.
// Reset empties the table and restores retry interval 2 and timeout 10.
module endpoint_pair_check_table #(
  parameter int Depth = epct_pkg::TableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  epct_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output epct_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  epct_pkg::cmd_t  cmd;
  epct_pkg::sts_t  sts;
  logic [IdxW-1:0] rd_idx, wr_idx;

  assign cfg_ready_o = 1'b1;

  epct_ctrl #(.Depth(Depth), .IdxW(IdxW), .CntW(CntW)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_kind_i (in_data_i.kind),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .rd_idx_o  (rd_idx),
    .wr_idx_o  (wr_idx)
  );

  epct_dpath #(.Depth(Depth), .IdxW(IdxW)) u_dpath (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .wr_idx_i  (wr_idx),
    .sts_o     (sts),
    .out_valid_o,
    .out_data_o,
    .out_stall_i
  );

endmodule
